// ----- design/sev_pkg.sv -----
// Shared types and constants for the Smagorinsky eddy viscosity block.
// No dependencies; imported by every module of the block.
`default_nettype none
package sev_pkg;

  // Register indexes of the configuration port.
  localparam logic CFG_MODEL_CONSTANT  = 1'b0;
  localparam logic CFG_SPACE_DIMENSION = 1'b1;

  localparam logic [15:0] CS_RESET  = 16'd11796;
  localparam logic [1:0]  DIM_RESET = 2'd3;
  localparam logic [1:0]  DIM_3D    = 2'd3;

  // Widths along the datapath.
  localparam int SQ_W    = 65;   // square of a 33-bit magnitude
  localparam int X_W     = 67;   // 2 S:S in Q32.32
  localparam int ROOT_W  = 35;   // floored root
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int SQRT_STAGES = ROOT_W;

  // One slot of the square root pipeline, with the scale factor riding along.
  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [63:0]       scale;
  } sqrt_slot_t;

endpackage
`default_nettype wire

// ----- design/sev_lane.sv -----
// One lane of the strain tensor: squares the sum of two gradient components.
// Depends on sev_pkg.
`default_nettype none
module sev_lane (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic                       use_lane,
  input  wire logic signed [31:0]         a,
  input  wire logic signed [31:0]         b,
  output logic [sev_pkg::SQ_W-1:0]        sq
);
  import sev_pkg::*;

  logic signed [32:0] sum;
  logic [32:0]        mag;
  logic [65:0]        prod;

  // Magnitude of the component sum, then its square.
  always_comb begin
    sum  = 33'(a) + 33'(b);
    mag  = sum[32] ? 33'(-sum) : 33'(sum);
    prod = 66'(mag) * 66'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= use_lane ? prod[SQ_W-1:0] : '0;
    end
  end

endmodule
`default_nettype wire

// ----- design/sev_sqrt_stage.sv -----
// One bit of the pipelined integer square root (restoring method).
// Depends on sev_pkg.
`default_nettype none
module sev_sqrt_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire sev_pkg::sqrt_slot_t d,
  output sev_pkg::sqrt_slot_t      q
);
  import sev_pkg::*;

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  logic             take;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    cur   = {d.rem, d.rad[RAD_W-1 -: 2]};
    trial = {1'b0, 1'b0, d.root, 2'b01};
    take  = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.rad   <= {d.rad[RAD_W-3:0], 2'b00};
      q.rem   <= take ? REM_W'(cur - trial) : REM_W'(cur);
      q.root  <= {d.root[ROOT_W-2:0], take};
      q.scale <= d.scale;
    end
  end

endmodule
`default_nettype wire

// ----- design/smagorinsky_eddy_viscosity.sv -----
// Pipeline from input transaction to result: 3 square, merge and scale stages,
// 35 square root stages and 2 multiply stages.
// Throughput: one cell per clock; the whole pipeline advances together and
// holds when the output result is not taken.
// Reset: synchronous, clears all valid flags, cs = 11796 and space_dimension = 3.
`default_nettype none
module smagorinsky_eddy_viscosity (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] grad_xx,
  input  wire logic [31:0] grad_xy,
  input  wire logic [31:0] grad_xz,
  input  wire logic [31:0] grad_yx,
  input  wire logic [31:0] grad_yy,
  input  wire logic [31:0] grad_yz,
  input  wire logic [31:0] grad_zx,
  input  wire logic [31:0] grad_zy,
  input  wire logic [31:0] grad_zz,
  input  wire logic [31:0] filter_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      eddy_viscosity,
  output logic             saturated
);
  import sev_pkg::*;

  logic [15:0] model_constant;
  logic [1:0]  space_dimension;
  logic        en;
  logic        dim3;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      model_constant  <= CS_RESET;
      space_dimension <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODEL_CONSTANT:  model_constant  <= cfg_data;
        CFG_SPACE_DIMENSION: space_dimension <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign dim3     = (space_dimension == DIM_3D);
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: six lanes square the diagonal terms and the off-diagonal sums.
  logic [SQ_W-1:0] sq_xx, sq_yy, sq_zz, sq_xy, sq_xz, sq_yz;

  sev_lane u_lane_xx (.clk, .en, .use_lane(1'b1), .a(grad_xx), .b(32'sd0), .sq(sq_xx));
  sev_lane u_lane_yy (.clk, .en, .use_lane(1'b1), .a(grad_yy), .b(32'sd0), .sq(sq_yy));
  sev_lane u_lane_zz (.clk, .en, .use_lane(dim3), .a(grad_zz), .b(32'sd0), .sq(sq_zz));
  sev_lane u_lane_xy (.clk, .en, .use_lane(1'b1), .a(grad_xy), .b(grad_yx), .sq(sq_xy));
  sev_lane u_lane_xz (.clk, .en, .use_lane(dim3), .a(grad_xz), .b(grad_zx), .sq(sq_xz));
  sev_lane u_lane_yz (.clk, .en, .use_lane(dim3), .a(grad_yz), .b(grad_zy), .sq(sq_yz));

  // Squares of cs and of the filter length, beside the lanes.
  logic [31:0] c2;
  logic [63:0] l2;
  logic        v1, v2, v3;

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= 32'(model_constant) * 32'(model_constant);
      l2 <= 64'(filter_length) * 64'(filter_length);
    end
  end

  // Stage 2: first level of the merge, and the two halves of cs^2 * l^2.
  logic [X_W-1:0] sum_a, sum_b, sum_c;
  logic [63:0]    kp_lo, kp_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_a <= (X_W'(sq_xx) << 1) + (X_W'(sq_yy) << 1);
      sum_b <= (X_W'(sq_zz) << 1) + X_W'(sq_xy);
      sum_c <= X_W'(sq_xz) + X_W'(sq_yz);
      kp_lo <= 64'(c2) * 64'(l2[31:0]);
      kp_hi <= 64'(c2) * 64'(l2[63:32]);
    end
  end

  // Stage 3: 2 S:S and the scale factor k = cs^2 * l^2 in Q32.32.
  logic [X_W-1:0] x_sum;
  logic [63:0]    scale;

  always_ff @(posedge clk) begin
    if (en) begin
      x_sum <= sum_a + sum_b + sum_c;
      scale <= kp_hi + {32'd0, kp_lo[63:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Square root pipeline, one root bit per stage.
  sqrt_slot_t slot [SQRT_STAGES+1];

  always_comb begin
    slot[0].valid = v3;
    slot[0].rad   = RAD_W'(x_sum);
    slot[0].rem   = '0;
    slot[0].root  = '0;
    slot[0].scale = scale;
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    sev_sqrt_stage u_stage (.clk, .rst, .en, .d(slot[s]), .q(slot[s+1]));
  end

  // Multiply k by the root as two 32 by 35 partial products.
  sqrt_slot_t        last;
  logic [66:0]       pm_lo, pm_hi;
  logic              vm;
  logic [98:0]       total;

  assign last = slot[SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      pm_lo <= 67'(last.scale[31:0]) * 67'(last.root);
      pm_hi <= 67'(last.scale[63:32]) * 67'(last.root);
    end
  end

  // Final stage: recombine, drop 32 fraction bits and saturate.
  assign total = {pm_hi, 32'd0} + {32'd0, pm_lo};

  always_ff @(posedge clk) begin
    if (en) begin
      saturated      <= (total[98:64] != '0);
      eddy_viscosity <= (total[98:64] != '0) ? 32'hFFFF_FFFF : total[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vm        <= last.valid;
      out_valid <= vm;
    end
  end

  // A saturated result always carries the maximum code.
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> eddy_viscosity == 32'hFFFF_FFFF)
    else $error("saturated result without maximum code");

  // A stalled result is never overwritten by the pipeline behind it.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(eddy_viscosity) && $stable(saturated))
    else $error("pending result changed while stalled");

  // Input is taken exactly when the pipeline can advance.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow pipeline advance");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule
`default_nettype wire
